FILE: src/ptsm_pkg.sv
// ----------------------------------------------------------------------------
// ptsm_pkg
// Shared types and constants of the page table slot map: field widths,
// request codes, the slot record layout and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ptsm_pkg;

	// default table size
	localparam int unsigned SLOTS_DEF = 512;

	// fixed field widths
	localparam int unsigned IDX_W = 9;
	localparam int unsigned CNT_W = 10;
	localparam int unsigned HDL_W = 16;

	// request codes
	localparam logic [1:0] REQ_FIND   = 2'd0;
	localparam logic [1:0] REQ_INSIDE = 2'd1;
	localparam logic [1:0] REQ_INSERT = 2'd2;
	localparam logic [1:0] REQ_REMOVE = 2'd3;

	// one slot record as held in the memory
	typedef struct packed {
		logic             valid;
		logic             is_table;
		logic [HDL_W-1:0] handle;
		logic [IDX_W-1:0] base;
		logic [CNT_W-1:0] run;
	} entry_t;

	// one result beat
	typedef struct packed {
		logic             slot_filled;
		logic [HDL_W-1:0] found_handle;
		logic             found_is_table;
		logic             inside_hit;
		logic             range_error;
	} result_t;

	// memory port enables
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} ram_ctl_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_FILL,
		ST_PUSH
	} seq_state_t;

endpackage

`default_nettype wire

FILE: src/ptsm_ram.sv
// ----------------------------------------------------------------------------
// ptsm_ram
// Generic simple dual port RAM: one write port, one read port, read data
// registered and held until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module ptsm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: src/ptsm_seq.sv
// ----------------------------------------------------------------------------
// ptsm_seq
// Request sequencer: clears the slot memory after reset, issues lookups,
// walks insert and remove runs one slot per cycle and builds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ptsm_seq
	import ptsm_pkg::*;
#(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// request beat
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [1:0]               req_type,
	input  wire logic [IDX_W-1:0]         slot_index,
	input  wire logic [CNT_W-1:0]         page_count,
	input  wire logic [HDL_W-1:0]         child_handle,
	input  wire logic                     child_is_table,
	// memory side
	output ram_ctl_t                      ram_ctl,
	output logic      [$clog2(SLOTS)-1:0] ram_wr_addr,
	output entry_t                        ram_wr_data,
	output logic      [$clog2(SLOTS)-1:0] ram_rd_addr,
	input  wire entry_t                   ram_rd_data,
	// result hand-off
	output logic                          push_valid,
	input  wire logic                     push_ready,
	output result_t                       push_res
);

	localparam int unsigned AW    = $clog2(SLOTS);
	localparam int unsigned EXT_W = (AW > IDX_W) ? AW : IDX_W;
	localparam int unsigned SUM_W = ($clog2(SLOTS + 1) > CNT_W + 1) ?
		$clog2(SLOTS + 1) : CNT_W + 1;
	localparam logic [AW-1:0]    LAST_ADDR = AW'(SLOTS - 1);
	localparam logic [SUM_W-1:0] SLOTS_SUM = SUM_W'(SLOTS);

	seq_state_t state_q, state_d;

	logic [AW-1:0]    addr_q;
	logic [CNT_W-1:0] left_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	entry_t           wr_entry_q;
	result_t          res_q;

	logic             accept;
	logic             is_update;
	logic [CNT_W-1:0] run;
	logic             run_err;
	logic [EXT_W-1:0] idx_ext;
	logic [AW-1:0]    idx_addr;
	entry_t           new_entry;
	entry_t           probe_entry;
	result_t          upd_res;
	result_t          lookup_res;
	logic             q_in_table;
	logic [CNT_W:0]   q_end;
	logic [CNT_W:0]   e_end;

	// incoming request decode
	always_comb begin
		accept    = in_valid && (state_q == ST_IDLE);
		is_update = (req_type == REQ_INSERT) || (req_type == REQ_REMOVE);
		run       = child_is_table ? CNT_W'(1) : page_count;
		run_err   = (SUM_W'(slot_index) + SUM_W'(run)) > SLOTS_SUM;
		idx_ext   = EXT_W'(slot_index);
		idx_addr  = idx_ext[AW-1:0];
		new_entry = '0;
		if (req_type == REQ_INSERT) begin
			new_entry.valid    = 1'b1;
			new_entry.is_table = child_is_table;
			new_entry.handle   = child_handle;
			new_entry.base     = slot_index;
			new_entry.run      = run;
		end
		probe_entry       = '0;
		probe_entry.valid = (req_type == REQ_INSIDE);
		upd_res             = '0;
		upd_res.range_error = run_err;
	end

	// find and inside answers from the slot read back
	always_comb begin
		q_in_table = SUM_W'(idx_q) < SLOTS_SUM;
		q_end      = (CNT_W+1)'(idx_q) + (CNT_W+1)'(cnt_q);
		e_end      = (CNT_W+1)'(ram_rd_data.base) + (CNT_W+1)'(ram_rd_data.run);
		lookup_res = '0;
		if (wr_entry_q.valid) begin
			// a lookup keeps its request kind in the valid bit of the latched record
			lookup_res.inside_hit = q_in_table && ram_rd_data.valid &&
				!ram_rd_data.is_table && (ram_rd_data.base <= idx_q) && (q_end <= e_end);
		end else if (q_in_table && ram_rd_data.valid) begin
			lookup_res.slot_filled    = 1'b1;
			lookup_res.found_handle   = ram_rd_data.handle;
			lookup_res.found_is_table = ram_rd_data.is_table;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (addr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (!is_update) begin
						state_d = ST_LOOKUP;
					end else if (run_err || (run == '0)) begin
						state_d = ST_PUSH;
					end else begin
						state_d = ST_FILL;
					end
				end
			end
			ST_LOOKUP: state_d = ST_PUSH;
			ST_FILL: begin
				if (left_q == CNT_W'(1)) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (push_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// outputs per state
	always_comb begin
		in_stall      = 1'b1;
		ram_ctl       = '0;
		ram_wr_addr   = addr_q;
		ram_wr_data   = wr_entry_q;
		ram_rd_addr   = idx_addr;
		push_valid    = 1'b0;
		push_res      = res_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_ctl.wr_en = 1'b1;
				ram_wr_data   = '0;
			end
			ST_IDLE: begin
				in_stall      = 1'b0;
				ram_ctl.rd_en = in_valid && !is_update;
			end
			ST_LOOKUP: ;
			ST_FILL: ram_ctl.wr_en = 1'b1;
			ST_PUSH: push_valid = 1'b1;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q  <= '0;
			left_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR || state_q == ST_FILL) begin
				addr_q <= addr_q + AW'(1);
				left_q <= left_q - CNT_W'(1);
			end else if (accept) begin
				addr_q <= idx_addr;
				left_q <= run;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= slot_index;
			cnt_q <= page_count;
			if (is_update) begin
				wr_entry_q <= new_entry;
				res_q      <= upd_res;
			end else begin
				wr_entry_q <= probe_entry;
			end
		end
		if (state_q == ST_LOOKUP) begin
			res_q <= lookup_res;
		end
	end

endmodule

`default_nettype wire

FILE: src/page_table_slot_map.sv
// ----------------------------------------------------------------------------
// page_table_slot_map
// Slot table of one shadow page table node: find, inside query, insert and
// remove of children over runs of slots.
// ----------------------------------------------------------------------------
// Usage: a request beat (req_type, slot_index, page_count, child_handle,
// child_is_table) is taken when in_valid is high and in_stall is low. Every
// request gives exactly one result beat on the out channel, taken when
// out_valid is high and out_stall is low.
// Find and inside make one memory read. Insert and remove write the run one
// slot per cycle through the single write port of the slot memory; a run of
// zero or a run past the table end writes no slot and goes to the result.
// One request is worked on at a time: the next is taken only once the result
// of the last has been handed to the output register.
// After reset the slot memory is swept to empty, one slot per cycle, over all
// SLOTS slots; in_stall stays high meanwhile.
// A stalled result waits in the output register; the next request is still
// taken and held finished until that register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module page_table_slot_map
	import ptsm_pkg::*;
#(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// request channel
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       req_type,
	input  wire logic [IDX_W-1:0] slot_index,
	input  wire logic [CNT_W-1:0] page_count,
	input  wire logic [HDL_W-1:0] child_handle,
	input  wire logic             child_is_table,
	// result channel
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  slot_filled,
	output logic      [HDL_W-1:0] found_handle,
	output logic                  found_is_table,
	output logic                  inside_hit,
	output logic                  range_error
);

	localparam int unsigned AW = $clog2(SLOTS);

	ram_ctl_t         ram_ctl;
	logic [AW-1:0]    ram_wr_addr;
	logic [AW-1:0]    ram_rd_addr;
	entry_t           ram_wr_data;
	entry_t           ram_rd_data;
	logic             push_valid;
	logic             push_ready;
	result_t          push_res;
	logic             out_valid_q;
	result_t          out_res_q;

	// request sequencer
	ptsm_seq #(
		.SLOTS (SLOTS)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.slot_index     (slot_index),
		.page_count     (page_count),
		.child_handle   (child_handle),
		.child_is_table (child_is_table),
		.ram_ctl        (ram_ctl),
		.ram_wr_addr    (ram_wr_addr),
		.ram_wr_data    (ram_wr_data),
		.ram_rd_addr    (ram_rd_addr),
		.ram_rd_data    (ram_rd_data),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_res       (push_res)
	);

	// slot memory
	ptsm_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (SLOTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_ctl.wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_ctl.rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// output register, loads when empty or its beat leaves this cycle
	assign push_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_valid && push_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && push_ready) begin
			out_res_q <= push_res;
		end
	end

	assign out_valid      = out_valid_q;
	assign slot_filled    = out_res_q.slot_filled;
	assign found_handle   = out_res_q.found_handle;
	assign found_is_table = out_res_q.found_is_table;
	assign inside_hit     = out_res_q.inside_hit;
	assign range_error    = out_res_q.range_error;

endmodule

`default_nettype wire

FILE: src/ptsm_checker.sv
// ----------------------------------------------------------------------------
// ptsm_checker
// Port level checks of the page table slot map, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptsm_checker
	import ptsm_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic             slot_filled,
	input wire logic [HDL_W-1:0] found_handle,
	input wire logic             found_is_table,
	input wire logic             inside_hit,
	input wire logic             range_error
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found_handle) &&
		$stable(slot_filled) && $stable(inside_hit) && $stable(range_error))
		else $error("result beat changed while stalled");

	// one request is in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while one was in flight");

	// a result answers one kind of request only
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({slot_filled, inside_hit, range_error}) <= 1)
		else $error("result mixes answers of several requests");

	// an empty slot reports no child
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !slot_filled |-> (found_handle == '0) && !found_is_table)
		else $error("empty slot reported child fields");

endmodule

bind page_table_slot_map ptsm_checker u_ptsm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.slot_filled    (slot_filled),
	.found_handle   (found_handle),
	.found_is_table (found_is_table),
	.inside_hit     (inside_hit),
	.range_error    (range_error)
);

`default_nettype wire
